>>> hw/rtl/water_enthalpy_phase_convert_top_assert.svh
// Assertion macros for the water enthalpy and phase converter.
// Included by modules that check their own logic; the macros expect clock and reset.
`ifndef WATER_ENTHALPY_PHASE_CONVERT_TOP_ASSERT_SVH
`define WATER_ENTHALPY_PHASE_CONVERT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WEPC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wepc implication check failed");
// Next-cycle implication.
`define WEPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wepc next-cycle check failed");
`else
`define WEPC_ASSERT_IMP(lbl, ante, cons)
`define WEPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/wepc_pkg.sv
// Shared types, widths and constants of the water enthalpy and phase converter.
// No dependencies; every other RTL module of the block imports this package.
`timescale 1ns / 1ps
package wepc_pkg;
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_W = FRACTION_BITS + 1;
   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   localparam int TEMP_W = 20;
   localparam int ENTH_W = 25;
   localparam int CP_W = 16;
   localparam int LH_W = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // Internal enthalpies are in centi-J/kg.
   localparam int EC_W = 32;
   localparam int BP_W = 33;
   localparam int H_W = 37;
   localparam int DIFF_W = 32;
   localparam int DVS_W = 31;
   localparam int DIV_W = 32;
   localparam int NA_W = 38;
   localparam int NUM_W = FRACTION_BITS + 33;
   localparam int QA_W = 32;

   localparam logic [TEMP_W-1:0] T_FUSE_LO = TEMP_W'(27265);
   localparam logic [TEMP_W-1:0] T_FUSE_HI = TEMP_W'(27365);
   localparam logic [TEMP_W-1:0] T_BOIL = TEMP_W'(37315);
   localparam logic [TEMP_W-1:0] LIQ_SPAN = TEMP_W'(9950);
   localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(1000000);
   localparam logic [ENTH_W-1:0] ENTH_MAX = '1;
   localparam logic [7:0] CENTI = 8'd100;

   typedef enum logic {
      OP_T2H = 1'b0,
      OP_H2S = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_ICE = 3'd0,
      PH_MUSHY = 3'd1,
      PH_LIQUID = 3'd2,
      PH_BOILING = 3'd3,
      PH_VAPOR = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ICE_CP = 3'd0,
      REG_LIQ_CP = 3'd1,
      REG_VAP_CP = 3'd2,
      REG_FUSION_LH = 3'd3,
      REG_VAPOR_LH = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic req_type;
      logic [TEMP_W-1:0] temperature_in;
      logic [ENTH_W-1:0] enthalpy_in;
   } req_item_type;

   typedef struct packed {
      logic [ENTH_W-1:0] enthalpy_out;
      logic [TEMP_W-1:0] temperature_out;
      logic [2:0] phase_out;
      logic [FRAC_W-1:0] solid_part;
      logic [FRAC_W-1:0] liquid_part;
      logic [FRAC_W-1:0] vapor_part;
      logic clipped;
   } rsp_item_type;

   typedef struct packed {
      logic [CP_W-1:0] ice_cp;
      logic [CP_W-1:0] liq_cp;
      logic [CP_W-1:0] vap_cp;
      logic [LH_W-1:0] fusion_lh;
      logic [LH_W-1:0] vapor_lh;
   } cfg_type;

   // One lane of the divider: partial remainder, numerator bits that
   // shift out while quotient bits shift in, and the divisor.
   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] nq;
      logic [DIV_W-1:0] div;
   } lane_type;

   typedef struct packed {
      logic valid;
      op_type op;
      phase_type phase;
      logic [ENTH_W-1:0] echo;
      lane_type a;
      lane_type b;
   } cell_type;
endpackage

>>> hw/rtl/wepc_prep.sv
// Front end of the converter: breakpoints, band selection and divider operands.
// Depends on wepc_pkg; feeds the first cell of the divider chain.
`timescale 1ns / 1ps
module wepc_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  req_valid,
   input  wepc_pkg::req_item_type req_item,
   input  wepc_pkg::cfg_type     cfg,
   output wepc_pkg::cell_type    head
);
   import wepc_pkg::*;

   typedef struct packed {
      logic valid;
      op_type op;
      logic [TEMP_W-1:0] t;
      logic [ENTH_W-1:0] e;
   } s1_type;

   typedef struct packed {
      logic valid;
      op_type op;
      phase_type band;
      phase_type phase;
      logic [TEMP_W-1:0] t;
      logic [ENTH_W-1:0] e;
      logic [EC_W-1:0] ec;
      logic [H_W-1:0] prod;
      logic [H_W-1:0] h;
      logic [BP_W-1:0] b1;
      logic [BP_W-1:0] b2;
      logic [BP_W-1:0] b3;
      logic [BP_W-1:0] b4;
      logic [BP_W-1:0] kf;
      logic [BP_W-1:0] kb;
      logic [BP_W-1:0] kv;
      logic [BP_W-1:0] bkv;
   } mid_type;

   typedef struct packed {
      logic valid;
      op_type op;
      phase_type phase;
      logic [ENTH_W-1:0] echo;
      logic [H_W-1:0] h;
      logic [DIFF_W-1:0] diff;
      logic [DVS_W-1:0] da;
      logic [DVS_W-1:0] db;
   } s6_type;

   s1_type s1_ff, s1_in;
   mid_type s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in, s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [CP_W-1:0] ci, cl, cv;
   logic [LH_W-1:0] lf, lv;
   logic [LH_W:0] clf;
   logic [LH_W:0] mul_a;
   logic [TEMP_W-1:0] mul_b;
   logic [LH_W+TEMP_W:0] prod_full;
   phase_type band;
   logic [BP_W-1:0] base0, base1;
   logic [BP_W-1:0] diff_full;
   logic [NA_W-1:0] na;
   logic [DIFF_W-1:0] nb_src;

   // A heat register written as zero behaves as one.
   assign ci = (cfg.ice_cp == '0) ? CP_W'(1) : cfg.ice_cp;
   assign cl = (cfg.liq_cp == '0) ? CP_W'(1) : cfg.liq_cp;
   assign cv = (cfg.vap_cp == '0) ? CP_W'(1) : cfg.vap_cp;
   assign lf = (cfg.fusion_lh == '0) ? LH_W'(1) : cfg.fusion_lh;
   assign lv = (cfg.vapor_lh == '0) ? LH_W'(1) : cfg.vapor_lh;
   assign clf = (LH_W+1)'(cl) + (LH_W+1)'(lf);

   always_comb begin
      s1_in.valid = req_valid;
      s1_in.op = op_type'(req_item.req_type);
      s1_in.t = req_item.temperature_in;
      s1_in.e = req_item.enthalpy_in;
   end

   // Temperature band and the one product that the forward direction needs.
   always_comb begin
      if (s1_ff.t < T_FUSE_LO) begin
         band = PH_ICE;
         mul_a = (LH_W+1)'(ci);
         mul_b = s1_ff.t;
      end else if (s1_ff.t <= T_FUSE_HI) begin
         band = PH_MUSHY;
         mul_a = clf;
         mul_b = s1_ff.t - T_FUSE_LO;
      end else if (s1_ff.t < T_BOIL) begin
         band = PH_LIQUID;
         mul_a = (LH_W+1)'(cl);
         mul_b = s1_ff.t - T_FUSE_HI;
      end else begin
         band = PH_VAPOR;
         mul_a = (LH_W+1)'(cv);
         mul_b = s1_ff.t - T_BOIL;
      end
      prod_full = (LH_W+TEMP_W+1)'(mul_a) * (LH_W+TEMP_W+1)'(mul_b);
   end

   always_comb begin
      s2_in = '0;
      s2_in.valid = s1_ff.valid;
      s2_in.op = s1_ff.op;
      s2_in.band = band;
      s2_in.t = s1_ff.t;
      s2_in.e = s1_ff.e;
      s2_in.ec = EC_W'(s1_ff.e) * EC_W'(CENTI);
      s2_in.prod = prod_full[H_W-1:0];
      s2_in.b1 = BP_W'(ci) * BP_W'(T_FUSE_LO);
      s2_in.kf = BP_W'(clf) * BP_W'(CENTI);
      s2_in.kb = BP_W'(cl) * BP_W'(LIQ_SPAN);
      s2_in.kv = BP_W'(lv) * BP_W'(CENTI);
   end

   always_comb begin
      s3_in = s2_ff;
      s3_in.b2 = s2_ff.b1 + s2_ff.kf;
      s3_in.bkv = s2_ff.kb + s2_ff.kv;
   end

   always_comb begin
      s4_in = s3_ff;
      s4_in.b3 = s3_ff.b2 + s3_ff.kb;
      s4_in.b4 = s3_ff.b2 + s3_ff.bkv;
   end

   always_comb begin
      s5_in = s4_ff;
      case (s4_ff.band)
         PH_MUSHY: base0 = s4_ff.b1;
         PH_LIQUID: base0 = s4_ff.b2;
         PH_VAPOR: base0 = s4_ff.b4;
         default: base0 = '0;
      endcase
      s5_in.h = H_W'(base0) + s4_ff.prod;
      if ({1'b0, s4_ff.ec} < s4_ff.b1) begin
         s5_in.phase = PH_ICE;
      end else if ({1'b0, s4_ff.ec} <= s4_ff.b2) begin
         s5_in.phase = PH_MUSHY;
      end else if ({1'b0, s4_ff.ec} <= s4_ff.b3) begin
         s5_in.phase = PH_LIQUID;
      end else if ({1'b0, s4_ff.ec} <= s4_ff.b4) begin
         s5_in.phase = PH_BOILING;
      end else begin
         s5_in.phase = PH_VAPOR;
      end
   end

   // Offset into the enthalpy band and the divisors of both lanes.
   always_comb begin
      case (s5_ff.phase)
         PH_MUSHY: base1 = s5_ff.b1;
         PH_LIQUID: base1 = s5_ff.b2;
         PH_BOILING: base1 = s5_ff.b3;
         PH_VAPOR: base1 = s5_ff.b4;
         default: base1 = '0;
      endcase
      diff_full = {1'b0, s5_ff.ec} - base1;
      s6_in.valid = s5_ff.valid;
      s6_in.op = s5_ff.op;
      s6_in.phase = s5_ff.phase;
      s6_in.h = s5_ff.h;
      s6_in.diff = diff_full[DIFF_W-1:0];
      s6_in.da = DVS_W'(1);
      s6_in.db = DVS_W'(1);
      if (s5_ff.op == OP_T2H) begin
         s6_in.echo = ENTH_W'(s5_ff.t);
         s6_in.da = DVS_W'(CENTI);
      end else begin
         s6_in.echo = s5_ff.e;
         case (s5_ff.phase)
            PH_ICE: s6_in.da = DVS_W'(ci);
            PH_MUSHY: begin
               s6_in.da = s5_ff.kf[DVS_W-1:0];
               s6_in.db = s5_ff.kf[DVS_W-1:0];
            end
            PH_LIQUID: s6_in.da = DVS_W'(cl);
            PH_BOILING: s6_in.db = s5_ff.kv[DVS_W-1:0];
            PH_VAPOR: s6_in.da = DVS_W'(cv);
            default: s6_in.da = DVS_W'(1);
         endcase
      end
   end

   // Rounded division n/d is run as floor((2n + d) / 2d).
   always_comb begin
      if (s6_ff.op == OP_T2H) begin
         na = NA_W'(s6_ff.h);
      end else if (s6_ff.phase == PH_MUSHY) begin
         na = NA_W'(s6_ff.diff) * NA_W'(CENTI);
      end else begin
         na = NA_W'(s6_ff.diff);
      end
      if (s6_ff.op == OP_H2S && (s6_ff.phase == PH_MUSHY || s6_ff.phase == PH_BOILING)) begin
         nb_src = s6_ff.diff;
      end else begin
         nb_src = '0;
      end
      head.valid = s6_ff.valid;
      head.op = s6_ff.op;
      head.phase = s6_ff.phase;
      head.echo = s6_ff.echo;
      head.a.rem = '0;
      head.a.nq = NUM_W'({na, 1'b0}) + NUM_W'(s6_ff.da);
      head.a.div = {s6_ff.da, 1'b0};
      head.b.rem = '0;
      head.b.nq = (NUM_W'(nb_src) << (FRACTION_BITS + 1)) + NUM_W'(s6_ff.db);
      head.b.div = {s6_ff.db, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end
endmodule

>>> hw/rtl/wepc_cell.sv
// One cell of the divider chain: a restoring-division step on each of two lanes.
// Depends on wepc_pkg; instantiated in a row by the top level.
`timescale 1ns / 1ps
module wepc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  wepc_pkg::cell_type prev_cell,
   output wepc_pkg::cell_type next_cell
);
   import wepc_pkg::*;

   cell_type stage_ff, stage_in;

   // The remainder stays below the divisor, so one compare and subtract
   // settles each quotient bit.
   function automatic lane_type div_step(lane_type l);
      logic [DIV_W:0] rs;
      logic ge;
      lane_type r;
      rs = {l.rem, l.nq[NUM_W-1]};
      ge = (rs >= {1'b0, l.div});
      r.div = l.div;
      r.rem = ge ? DIV_W'(rs - {1'b0, l.div}) : rs[DIV_W-1:0];
      r.nq = {l.nq[NUM_W-2:0], ge};
      return r;
   endfunction

   always_comb begin
      stage_in = prev_cell;
      stage_in.a = div_step(prev_cell.a);
      stage_in.b = div_step(prev_cell.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign next_cell = stage_ff;
endmodule

>>> hw/rtl/wepc_finish.sv
// Result assembly and output register of the converter.
// Depends on wepc_pkg; takes the last cell of the divider chain.
`timescale 1ns / 1ps
module wepc_finish (
   input  logic                   clock,
   input  logic                   reset,
   input  wepc_pkg::cell_type     tail,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output wepc_pkg::rsp_item_type rsp_item
);
   import wepc_pkg::*;

   logic rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [QA_W-1:0] qa;
   logic [FRAC_W-1:0] qb;
   logic [TEMP_W-1:0] toff;
   logic [QA_W-1:0] tadd;
   logic [QA_W:0] tv;

   assign qa = tail.a.nq[QA_W-1:0];
   assign qb = tail.b.nq[FRAC_W-1:0];

   always_comb begin
      rsp_item_in = '0;
      toff = '0;
      tadd = qa;
      tv = '0;
      if (tail.op == OP_T2H) begin
         rsp_item_in.temperature_out = tail.echo[TEMP_W-1:0];
         if (tail.a.nq > NUM_W'(ENTH_MAX)) begin
            rsp_item_in.enthalpy_out = ENTH_MAX;
            rsp_item_in.clipped = 1'b1;
         end else begin
            rsp_item_in.enthalpy_out = qa[ENTH_W-1:0];
         end
      end else begin
         rsp_item_in.enthalpy_out = tail.echo;
         rsp_item_in.phase_out = tail.phase;
         case (tail.phase)
            PH_ICE: rsp_item_in.solid_part = FRAC_ONE;
            PH_MUSHY: begin
               toff = T_FUSE_LO;
               rsp_item_in.liquid_part = qb;
               rsp_item_in.solid_part = FRAC_ONE - qb;
            end
            PH_LIQUID: begin
               toff = T_FUSE_HI;
               rsp_item_in.liquid_part = FRAC_ONE;
            end
            PH_BOILING: begin
               toff = T_BOIL;
               tadd = '0;
               rsp_item_in.vapor_part = qb;
               rsp_item_in.liquid_part = FRAC_ONE - qb;
            end
            PH_VAPOR: begin
               toff = T_BOIL;
               rsp_item_in.vapor_part = FRAC_ONE;
            end
            default: tadd = '0;
         endcase
         tv = {1'b0, tadd} + (QA_W+1)'(toff);
         if (tv > (QA_W+1)'(TEMP_MAX)) begin
            rsp_item_in.temperature_out = TEMP_MAX;
            rsp_item_in.clipped = 1'b1;
         end else begin
            rsp_item_in.temperature_out = tv[TEMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;
endmodule

>>> hw/rtl/water_enthalpy_phase_convert_top.sv
// Top level of the water temperature / enthalpy converter.
// Depends on wepc_pkg, wepc_prep, wepc_cell, wepc_finish and the assertion header.
//
// Usage: items enter on the req_ channel (req_valid, req_stall, req_item) and
// results leave on the rsp_ channel (rsp_valid, rsp_stall, rsp_item); an item
// moves at a clock edge with valid high and stall low. Opcode 0 turns a
// temperature into an enthalpy, opcode 1 an enthalpy into temperature, phase
// and mass fractions. Heats are written through csr_wr_en, csr_index and
// csr_wdata while no item is in flight.
// Items are taken one per cycle while req_stall is low. Between input and
// output lie six front-end stages, one divider cell per numerator bit
// (FRACTION_BITS + 33 cells, each settling one quotient bit on two lanes)
// and the output register.
// Reset is synchronous and returns the heat registers to their defaults and
// empties the pipeline. While the receiver stalls a waiting result, the
// pipeline keeps moving as long as the last cell is empty, so items are still
// taken; it holds and req_stall rises only when that cell holds a result too.
`timescale 1ns / 1ps
`include "water_enthalpy_phase_convert_top_assert.svh"
module water_enthalpy_phase_convert_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  wepc_pkg::req_item_type                req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output wepc_pkg::rsp_item_type                rsp_item,
   input  logic                                  csr_wr_en,
   input  logic [wepc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wepc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wepc_pkg::*;

   cfg_type cfg_ff;
   cell_type chain [NUM_W+1];
   logic en;
   logic [FRAC_W+1:0] frac_sum;
   logic frac_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ice_cp <= CP_W'(2100);
         cfg_ff.liq_cp <= CP_W'(4186);
         cfg_ff.vap_cp <= CP_W'(2010);
         cfg_ff.fusion_lh <= LH_W'(334000);
         cfg_ff.vapor_lh <= LH_W'(2257000);
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_ICE_CP: cfg_ff.ice_cp <= csr_wdata[CP_W-1:0];
            REG_LIQ_CP: cfg_ff.liq_cp <= csr_wdata[CP_W-1:0];
            REG_VAP_CP: cfg_ff.vap_cp <= csr_wdata[CP_W-1:0];
            REG_FUSION_LH: cfg_ff.fusion_lh <= csr_wdata[LH_W-1:0];
            REG_VAPOR_LH: cfg_ff.vapor_lh <= csr_wdata[LH_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline only holds when a result waits at the output and another
   // one is ready behind it in the last cell.
   assign en = !(rsp_valid && rsp_stall && chain[NUM_W].valid);
   assign req_stall = !en;

   wepc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .head      (chain[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      wepc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .prev_cell (chain[i]),
         .next_cell (chain[i+1])
      );
   end

   wepc_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .tail      (chain[NUM_W]),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign frac_sum = (FRAC_W+2)'(rsp_item.solid_part) + (FRAC_W+2)'(rsp_item.liquid_part)
                   + (FRAC_W+2)'(rsp_item.vapor_part);
   assign frac_ok = (frac_sum == (FRAC_W+2)'(FRAC_ONE))
                  || ((frac_sum == '0) && (rsp_item.phase_out == PH_ICE));

   `WEPC_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   `WEPC_ASSERT_IMP(a_frac_sum, rsp_valid, frac_ok)
   `WEPC_ASSERT_IMP(a_boil_temp, rsp_valid && (rsp_item.phase_out == PH_BOILING), rsp_item.temperature_out == T_BOIL)
   `WEPC_ASSERT_IMP(a_clip_sat, rsp_valid && rsp_item.clipped, (rsp_item.temperature_out == TEMP_MAX) || (rsp_item.enthalpy_out == ENTH_MAX))
   `WEPC_ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !chain[NUM_W].valid, !rsp_valid)
endmodule

>>> bench/tb_top.sv
// Self-checking bench for the water temperature / enthalpy phase converter.
// Depends on wepc_pkg and water_enthalpy_phase_convert_top; drives random traffic
// with random idles and stalls and checks every result against an in-bench predictor.
`timescale 1ns / 1ps
module tb_top;
   import wepc_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam longint unsigned T_LO = 27265;
   localparam longint unsigned T_HI = 27365;
   localparam longint unsigned T_BP = 37315;
   localparam longint unsigned Q_ONE = 64'd1 << FRACTION_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Copy of the heat registers as the block should hold them.
   logic [CP_W-1:0] heat_ice, heat_liq, heat_vap;
   logic [LH_W-1:0] latent_fuse, latent_boil;

   req_item_type pending_items[$];
   rsp_item_type expected_states[$];
   int idle_pct = 27;
   int stall_pct = 27;
   bit hold_sender = 1'b0;
   int errors = 0;
   int results_seen = 0;
   int op_count[2];
   int phase_count[5];
   int clip_count = 0;
   int cycles = 0;

   water_enthalpy_phase_convert_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned at_least_one(longint unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   // Breakpoints in centi-J/kg: ice end, mushy end, liquid end, boiling end.
   function automatic void breakpoints(output longint unsigned b1, b2, b3, b4);
      b1 = at_least_one(64'(heat_ice)) * T_LO;
      b2 = b1 + 100 * (at_least_one(64'(heat_liq)) + at_least_one(64'(latent_fuse)));
      b3 = b2 + at_least_one(64'(heat_liq)) * (T_BP - T_HI);
      b4 = b3 + 100 * at_least_one(64'(latent_boil));
   endfunction

   function automatic rsp_item_type predict_state(req_item_type r);
      longint unsigned ci, cl, cv, lf, b1, b2, b3, b4, h, t, ec, enth, temp, d;
      rsp_item_type o;
      ci = at_least_one(64'(heat_ice));
      cl = at_least_one(64'(heat_liq));
      cv = at_least_one(64'(heat_vap));
      lf = at_least_one(64'(latent_fuse));
      breakpoints(b1, b2, b3, b4);
      o = '0;
      if (r.req_type == OP_T2H) begin
         t = 64'(r.temperature_in);
         if (t < T_LO) h = ci * t;
         else if (t <= T_HI) h = b1 + (cl + lf) * (t - T_LO);
         else if (t < T_BP) h = b2 + cl * (t - T_HI);
         else h = b4 + cv * (t - T_BP);
         enth = (h + 50) / 100;
         if (enth > ENTH_MAX) begin
            enth = 64'(ENTH_MAX);
            o.clipped = 1'b1;
         end
         o.enthalpy_out = enth[ENTH_W-1:0];
         o.temperature_out = r.temperature_in;
      end else begin
         ec = 64'(r.enthalpy_in) * 100;
         o.enthalpy_out = r.enthalpy_in;
         if (ec < b1) begin
            temp = round_div(ec, ci);
            o.phase_out = PH_ICE;
            o.solid_part = FRAC_ONE;
         end else if (ec <= b2) begin
            d = ec - b1;
            temp = T_LO + round_div(100 * d, b2 - b1);
            o.liquid_part = FRAC_W'(round_div(Q_ONE * d, b2 - b1));
            o.solid_part = FRAC_W'(Q_ONE - round_div(Q_ONE * d, b2 - b1));
            o.phase_out = PH_MUSHY;
         end else if (ec <= b3) begin
            temp = T_HI + round_div(ec - b2, cl);
            o.liquid_part = FRAC_ONE;
            o.phase_out = PH_LIQUID;
         end else if (ec <= b4) begin
            temp = T_BP;
            o.vapor_part = FRAC_W'(round_div(Q_ONE * (ec - b3), b4 - b3));
            o.liquid_part = FRAC_W'(Q_ONE - round_div(Q_ONE * (ec - b3), b4 - b3));
            o.phase_out = PH_BOILING;
         end else begin
            temp = T_BP + round_div(ec - b4, cv);
            o.vapor_part = FRAC_ONE;
            o.phase_out = PH_VAPOR;
         end
         if (temp > TEMP_MAX) begin
            temp = 64'(TEMP_MAX);
            o.clipped = 1'b1;
         end
         o.temperature_out = temp[TEMP_W-1:0];
      end
      return o;
   endfunction

   // Sender: a new item goes out only once the current one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_states.push_back(predict_state(req_item));
            op_count[req_item.req_type]++;
         end
         if (pending_items.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
            req_item <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each result taken against the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_states.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               want = expected_states.pop_front();
               if (rsp_item !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: enth %0d/%0d temp %0d/%0d phase %0d/%0d sol %0d/%0d liq %0d/%0d vap %0d/%0d clip %0d/%0d (exp/got)",
                        want.enthalpy_out, rsp_item.enthalpy_out,
                        want.temperature_out, rsp_item.temperature_out,
                        want.phase_out, rsp_item.phase_out,
                        want.solid_part, rsp_item.solid_part,
                        want.liquid_part, rsp_item.liquid_part,
                        want.vapor_part, rsp_item.vapor_part,
                        want.clipped, rsp_item.clipped);
               end
            end
            if (rsp_item.phase_out <= PH_VAPOR) phase_count[rsp_item.phase_out]++;
            if (rsp_item.clipped) clip_count++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic req_item_type random_noise();
      req_item_type r;
      r.req_type = op_type'($urandom_range(1));
      r.temperature_in = TEMP_W'($urandom());
      r.enthalpy_in = ENTH_W'($urandom());
      return r;
   endfunction

   function automatic req_item_type temp_item(longint unsigned t);
      req_item_type r;
      r = random_noise();
      r.req_type = OP_T2H;
      r.temperature_in = t[TEMP_W-1:0];
      return r;
   endfunction

   function automatic req_item_type enth_item(longint unsigned e);
      req_item_type r;
      r = random_noise();
      r.req_type = OP_H2S;
      r.enthalpy_in = (e > ENTH_MAX) ? ENTH_MAX : e[ENTH_W-1:0];
      return r;
   endfunction

   task automatic queue_random(int n);
      longint unsigned bp[4];
      longint unsigned c, top;
      int sel;
      breakpoints(bp[0], bp[1], bp[2], bp[3]);
      top = bp[3] / 100 + 2 * at_least_one(64'(heat_vap)) * 1000;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(9);
         if ($urandom_range(1) == 0) begin
            case (sel)
               0, 1, 2: begin
                  c = (sel == 0) ? T_LO : (sel == 1) ? T_HI : T_BP;
                  pending_items.push_back(temp_item(c + $urandom_range(4) - 2));
               end
               3: pending_items.push_back(temp_item($urandom()));
               default: pending_items.push_back(temp_item($urandom_range(TEMP_MAX)));
            endcase
         end else begin
            case (sel)
               0, 1, 2, 3: begin
                  c = bp[sel] / 100 + 2;
                  pending_items.push_back(enth_item(c - $urandom_range(4)));
               end
               4: pending_items.push_back(enth_item($urandom()));
               default: pending_items.push_back(enth_item({$urandom()} % (top + 1)));
            endcase
         end
      end
   endtask

   // Writes are issued back to back; the enable drops after the last one.
   task automatic write_heat(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_ICE_CP: heat_ice = v[CP_W-1:0];
         REG_LIQ_CP: heat_liq = v[CP_W-1:0];
         REG_VAP_CP: heat_vap = v[CP_W-1:0];
         REG_FUSION_LH: latent_fuse = v;
         REG_VAPOR_LH: latent_boil = v;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_states.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      longint unsigned bp[4];
      heat_ice = 2100;
      heat_liq = 4186;
      heat_vap = 2010;
      latent_fuse = 334000;
      latent_boil = 2257000;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: band edges in both directions at the reset heats.
      pending_items.push_back(temp_item(0));
      pending_items.push_back(temp_item(T_LO - 1));
      pending_items.push_back(temp_item(T_LO));
      pending_items.push_back(temp_item(T_HI));
      pending_items.push_back(temp_item(T_HI + 1));
      pending_items.push_back(temp_item(T_BP - 1));
      pending_items.push_back(temp_item(T_BP));
      pending_items.push_back(temp_item(64'(TEMP_MAX)));
      pending_items.push_back(temp_item(64'hFFFFF));
      breakpoints(bp[0], bp[1], bp[2], bp[3]);
      pending_items.push_back(enth_item(0));
      for (int k = 0; k < 4; k++) begin
         pending_items.push_back(enth_item(bp[k] / 100));
         pending_items.push_back(enth_item(bp[k] / 100 + 1));
      end
      pending_items.push_back(enth_item(64'(ENTH_MAX)));
      queue_random(80);
      drain();

      // Largest heats: most temperatures saturate the enthalpy.
      write_heat(REG_ICE_CP, 24'hFFFF);
      write_heat(REG_LIQ_CP, 24'hFFFF);
      write_heat(REG_VAP_CP, 24'hFFFF);
      write_heat(REG_FUSION_LH, 24'hFFFFFF);
      write_heat(REG_VAPOR_LH, 24'hFFFFFF);
      end_writes();
      queue_random(100);
      // Let the sender wait for a full drain partway through.
      while (pending_items.size() > 50) @(negedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_states.size() > 0) @(negedge clock);
      hold_sender = 1'b0;
      drain();

      // Zero heats act as one; vapor temperatures saturate.
      write_heat(REG_ICE_CP, '0);
      write_heat(REG_LIQ_CP, '0);
      write_heat(REG_VAP_CP, '0);
      write_heat(REG_FUSION_LH, '0);
      write_heat(REG_VAPOR_LH, '0);
      write_heat(REG_UNUSED, CSR_DATA_W'($urandom()));
      end_writes();
      queue_random(100);
      drain();

      // Random heats, sent and received with no idles at all.
      write_heat(REG_ICE_CP, CSR_DATA_W'($urandom_range(1, 65535)));
      write_heat(REG_LIQ_CP, CSR_DATA_W'($urandom_range(1, 65535)));
      write_heat(REG_VAP_CP, CSR_DATA_W'($urandom_range(1, 65535)));
      write_heat(REG_FUSION_LH, CSR_DATA_W'($urandom_range(1, 24'hFFFFFF)));
      write_heat(REG_VAPOR_LH, CSR_DATA_W'($urandom_range(1, 24'hFFFFFF)));
      end_writes();
      idle_pct = 0;
      stall_pct = 0;
      queue_random(100);
      drain();
      idle_pct = 27;
      stall_pct = 27;

      // Ice, liquid and fusion heats at their legal minimum of one; random vapor heat and latent.
      write_heat(REG_ICE_CP, CSR_DATA_W'(1));
      write_heat(REG_LIQ_CP, CSR_DATA_W'(1));
      write_heat(REG_VAP_CP, CSR_DATA_W'($urandom_range(1, 8000)));
      write_heat(REG_FUSION_LH, CSR_DATA_W'(1));
      write_heat(REG_VAPOR_LH, CSR_DATA_W'($urandom_range(1, 3000000)));
      end_writes();
      queue_random(100);
      drain();

      $display("covered %0d temperature and %0d enthalpy items, %0d results, %0d clipped",
         op_count[OP_T2H], op_count[OP_H2S], results_seen, clip_count);
      $display("phases seen: ice %0d mushy %0d liquid %0d boiling %0d vapor %0d",
         phase_count[PH_ICE], phase_count[PH_MUSHY], phase_count[PH_LIQUID],
         phase_count[PH_BOILING], phase_count[PH_VAPOR]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
